// File: design/ltpv_pkg.sv
package ltpv_pkg;

    localparam int LEVER_W     = 16;
    localparam int LEVEL_W     = 12;
    localparam int DUTY_W      = 16;
    localparam int CODE_W      = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Quotient and divisor widths of the iterative dividers.
    localparam int PROD_W = LEVEL_W + DUTY_W;
    localparam int DEN_W  = LEVER_W;

    localparam int unsigned FULL_SCALE_DEF    = 4095;
    localparam int unsigned VALVE_ENABLE_DEF  = 200;

    localparam logic [LEVEL_W-1:0] DAC_TOP    = 12'd4095;
    localparam logic [LEVER_W:0]   VALVE_HYST = 17'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_START   = 3'd0,
        REG_PWM_KNEE    = 3'd1,
        REG_PWM_END     = 3'd2,
        REG_PWM_MIN     = 3'd3,
        REG_PWM_MAX     = 3'd4,
        REG_THR_START   = 3'd5,
        REG_THR_IDLE    = 3'd6,
        REG_RELAY_LEVEL = 3'd7
    } t_reg_idx;

    localparam logic [LEVEL_W-1:0] RST_PWM_START   = 12'd100;
    localparam logic [LEVEL_W-1:0] RST_PWM_KNEE    = 12'd400;
    localparam logic [LEVEL_W-1:0] RST_PWM_END     = 12'd3900;
    localparam logic [DUTY_W-1:0]  RST_PWM_MIN     = 16'd100;
    localparam logic [DUTY_W-1:0]  RST_PWM_MAX     = 16'd500;
    localparam logic [LEVEL_W-1:0] RST_THR_START   = 12'd2000;
    localparam logic [CODE_W-1:0]  RST_THR_IDLE    = 12'd800;
    localparam logic [LEVEL_W-1:0] RST_RELAY_LEVEL = 12'd2000;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_start;
        logic [LEVEL_W-1:0] pwm_knee;
        logic [LEVEL_W-1:0] pwm_end;
        logic [DUTY_W-1:0]  pwm_min;
        logic [DUTY_W-1:0]  pwm_max;
        logic [LEVEL_W-1:0] thr_start;
        logic [CODE_W-1:0]  thr_idle;
        logic [LEVEL_W-1:0] relay_level;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef enum logic [1:0] {
        SEG_ZERO = 2'd0,
        SEG_FAST = 2'd1,
        SEG_SLOW = 2'd2,
        SEG_MAX  = 2'd3
    } t_seg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

// File: design/ltpv_cfg.sv
module ltpv_cfg import ltpv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wen) begin
            case (i_cfg_idx)
                REG_PWM_START:   n_cfg.pwm_start   = i_cfg_data[LEVEL_W-1:0];
                REG_PWM_KNEE:    n_cfg.pwm_knee    = i_cfg_data[LEVEL_W-1:0];
                REG_PWM_END:     n_cfg.pwm_end     = i_cfg_data[LEVEL_W-1:0];
                REG_PWM_MIN:     n_cfg.pwm_min     = i_cfg_data[DUTY_W-1:0];
                REG_PWM_MAX:     n_cfg.pwm_max     = i_cfg_data[DUTY_W-1:0];
                REG_THR_START:   n_cfg.thr_start   = i_cfg_data[LEVEL_W-1:0];
                REG_THR_IDLE:    n_cfg.thr_idle    = i_cfg_data[CODE_W-1:0];
                REG_RELAY_LEVEL: n_cfg.relay_level = i_cfg_data[LEVEL_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pwm_start   <= RST_PWM_START;
            r_cfg.pwm_knee    <= RST_PWM_KNEE;
            r_cfg.pwm_end     <= RST_PWM_END;
            r_cfg.pwm_min     <= RST_PWM_MIN;
            r_cfg.pwm_max     <= RST_PWM_MAX;
            r_cfg.thr_start   <= RST_THR_START;
            r_cfg.thr_idle    <= RST_THR_IDLE;
            r_cfg.relay_level <= RST_RELAY_LEVEL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/ltpv_div.sv
module ltpv_div import ltpv_pkg::*; #(
    parameter int NUM_W = PROD_W,
    parameter int DW    = DEN_W
) (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_step,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DW-1:0]    i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [NUM_W-1:0] r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             fits;

    // Restoring division, one quotient bit per step, most significant first.
    assign rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fits   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (i_step) begin
            r_quo <= {r_quo[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DW-1:0] : rem_sh[DW-1:0];
        end
    end

    assign o_quo = r_quo;

endmodule

// File: design/ltpv_datapath.sv
module ltpv_datapath import ltpv_pkg::*; #(
    parameter int unsigned FULL_SCALE         = FULL_SCALE_DEF,
    parameter int unsigned VALVE_ENABLE_LEVEL = VALVE_ENABLE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  t_cfg                   i_cfg,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int EXT = LEVER_W - LEVEL_W;
    localparam logic [LEVER_W-1:0] FS  = LEVER_W'(FULL_SCALE);
    localparam logic [LEVER_W-1:0] VEL = LEVER_W'(VALVE_ENABLE_LEVEL);

    logic [LEVER_W-1:0] lever;
    logic [LEVER_W-1:0] a_in;
    logic               valve_off;
    logic               valve_on;

    logic [LEVER_W-1:0] r_a;
    logic               r_valve_a;
    logic               r_valve_b;

    logic [LEVER_W-1:0] end_x, knee_x, start_x, ts_x, relay_x;
    t_seg               seg;
    logic [LEVER_W-1:0] off_slow_w, off_fast_w;
    logic [DUTY_W:0]    span;
    logic [DUTY_W-1:0]  mag;
    logic [LEVEL_W-1:0] mul_a;
    logic [DUTY_W-1:0]  mul_b;
    logic [PROD_W-1:0]  duty_num;
    logic [LEVEL_W-1:0] duty_den;
    logic               thr_act;
    logic [LEVER_W-1:0] thr_off;
    logic [LEVEL_W-1:0] thr_gain;
    logic [PROD_W-1:0]  thr_num;
    logic [DEN_W-1:0]   thr_den;

    t_seg               r_seg;
    logic               r_neg;
    logic               r_slow_zero;
    logic               r_thr_act;

    logic [PROD_W-1:0]  duty_quo;
    logic [PROD_W-1:0]  thr_quo;
    logic [DUTY_W-1:0]  dq;
    logic [DUTY_W-1:0]  duty;
    logic [CODE_W-1:0]  thr_code;
    logic               relay;
    logic [OUT_TDATA_W-1:0] r_out;

    assign lever     = i_s_tdata[LEVER_W-1:0];
    assign a_in      = (lever >= FS) ? FS : lever;
    assign valve_off = ({1'b0, a_in} + VALVE_HYST) < {1'b0, VEL};
    assign valve_on  = (a_in >= VEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_a <= 1'b0;
            r_valve_b <= 1'b0;
        end else if (i_cmd.capture) begin
            if (valve_off) begin
                r_valve_a <= 1'b0;
                r_valve_b <= 1'b0;
            end else if (valve_on) begin
                r_valve_a <= i_s_tdata[LEVER_W];
                r_valve_b <= i_s_tdata[LEVER_W+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a <= a_in;
        end
    end

    assign end_x   = {{EXT{1'b0}}, i_cfg.pwm_end};
    assign knee_x  = {{EXT{1'b0}}, i_cfg.pwm_knee};
    assign start_x = {{EXT{1'b0}}, i_cfg.pwm_start};
    assign ts_x    = {{EXT{1'b0}}, i_cfg.thr_start};
    assign relay_x = {{EXT{1'b0}}, i_cfg.relay_level};

    always_comb begin
        if (r_a > end_x) begin
            seg = SEG_MAX;
        end else if (r_a >= knee_x) begin
            seg = SEG_SLOW;
        end else if (r_a >= start_x) begin
            seg = SEG_FAST;
        end else begin
            seg = SEG_ZERO;
        end
    end

    assign off_slow_w = r_a - knee_x;
    assign off_fast_w = r_a - start_x;
    assign span       = {1'b0, i_cfg.pwm_max} - {1'b0, i_cfg.pwm_min};
    assign mag        = span[DUTY_W] ? DUTY_W'(-span) : span[DUTY_W-1:0];
    assign mul_a      = (seg == SEG_SLOW) ? off_slow_w[LEVEL_W-1:0] : off_fast_w[LEVEL_W-1:0];
    assign mul_b      = (seg == SEG_SLOW) ? mag : i_cfg.pwm_min;
    assign duty_num   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign duty_den   = (seg == SEG_SLOW) ? (i_cfg.pwm_end - i_cfg.pwm_knee)
                                          : (i_cfg.pwm_knee - i_cfg.pwm_start);

    assign thr_act  = (r_a > ts_x) && (FS > ts_x);
    assign thr_off  = r_a - ts_x;
    assign thr_gain = DAC_TOP - i_cfg.thr_idle;
    assign thr_num  = PROD_W'(thr_off) * PROD_W'(thr_gain);
    assign thr_den  = FS - ts_x;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg       <= seg;
            r_neg       <= span[DUTY_W];
            r_slow_zero <= (i_cfg.pwm_end == i_cfg.pwm_knee);
            r_thr_act   <= thr_act;
        end
    end

    ltpv_div #(
        .NUM_W (PROD_W),
        .DW    (DEN_W)
    ) u_duty_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step),
        .i_num  (duty_num),
        .i_den  ({{EXT{1'b0}}, duty_den}),
        .o_quo  (duty_quo)
    );

    ltpv_div #(
        .NUM_W (PROD_W),
        .DW    (DEN_W)
    ) u_thr_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.load),
        .i_step (i_cmd.step),
        .i_num  (thr_num),
        .i_den  (thr_den),
        .o_quo  (thr_quo)
    );

    assign dq = duty_quo[DUTY_W-1:0];

    always_comb begin
        case (r_seg)
            SEG_MAX:  duty = i_cfg.pwm_max;
            SEG_FAST: duty = dq;
            SEG_SLOW: begin
                if (r_slow_zero) begin
                    duty = i_cfg.pwm_min;
                end else if (r_neg) begin
                    duty = i_cfg.pwm_min - dq;
                end else begin
                    duty = i_cfg.pwm_min + dq;
                end
            end
            default:  duty = '0;
        endcase
    end

    assign thr_code = r_thr_act ? (thr_quo[CODE_W-1:0] + i_cfg.thr_idle) : i_cfg.thr_idle;
    assign relay    = (r_a >= relay_x);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= {1'b0, r_valve_b, r_valve_a, relay, thr_code, duty};
        end
    end

    assign o_m_tdata = r_out;

endmodule

// File: design/ltpv_ctrl.sv
module ltpv_ctrl import ltpv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_m_tready,
    output logic o_s_tready,
    output logic o_m_tvalid,
    output t_cmd o_cmd
);

    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_valid, n_valid;
    t_cmd               cmd;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid && !i_m_tready;
        cmd     = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.capture = 1'b1;
                    n_state     = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.load = 1'b1;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_valid || i_m_tready) begin
                    cmd.finish = 1'b1;
                    n_valid    = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE) && i_rst_n;
    assign o_m_tvalid = r_valid;
    assign o_cmd      = cmd;

endmodule

// File: design/lever_to_pwm_throttle_valve_map_top.sv
// Channel   Direction  Beat contents (lowest bit first)
// s         in         tdata: lever_value[15:0], hopper_up[16], hopper_down[17]
// m         out        tdata: pwm_duty[15:0], throttle_code[27:16], relay_on[28],
//                             valve_a_drive[29], valve_b_drive[30]
// cfg       in         write enable, 3-bit register index, 16-bit data
//
// A beat is taken in ST_IDLE; ST_MUL loads the two products into the restoring dividers,
// which run 28 steps in parallel in ST_DIV, and ST_FIN forms the result, so no new
// beat is taken until the item is through. Reset is synchronous and active
// low; it restores the register defaults and turns both valves off. A waiting result
// does not stop the next beat being taken, but the following result is held until
// the waiting one has been taken.
module lever_to_pwm_throttle_valve_map_top import ltpv_pkg::*; #(
    parameter int unsigned FULL_SCALE         = FULL_SCALE_DEF,
    parameter int unsigned VALVE_ENABLE_LEVEL = VALVE_ENABLE_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // lever_value, hopper_up, hopper_down
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // pwm_duty, throttle_code, relay_on, valve_a_drive, valve_b_drive
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_wen,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;

    ltpv_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ltpv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (cmd)
    );

    ltpv_datapath #(
        .FULL_SCALE         (FULL_SCALE),
        .VALVE_ENABLE_LEVEL (VALVE_ENABLE_LEVEL)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_cfg     (cfg),
        .i_s_tdata (i_s_tdata),
        .o_m_tdata (o_m_tdata)
    );

endmodule

// File: test/lever_to_pwm_throttle_valve_map_top_tb.sv
`timescale 1ns / 1ps

module lever_to_pwm_throttle_valve_map_top_tb;
    import ltpv_pkg::*;

    typedef struct packed {
        logic [LEVER_W-1:0] lever;
        logic               up;
        logic               down;
    } t_lever_beat;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [CODE_W-1:0] code;
        logic              relay;
        logic              valve_a;
        logic              valve_b;
    } t_actuator_cmd;

    localparam longint FS      = longint'(FULL_SCALE_DEF);
    localparam longint VEN     = longint'(VALVE_ENABLE_DEF);
    localparam int     PHASES  = 8;
    localparam int     PER_PHASE = 65;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   i_cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_lever_beat   lever_beats[$];
    t_actuator_cmd actuator_cmds_due[$];
    t_lever_beat   beat_on_bus;

    t_cfg model_cfg = '{
        pwm_start: RST_PWM_START, pwm_knee: RST_PWM_KNEE, pwm_end: RST_PWM_END,
        pwm_min: RST_PWM_MIN, pwm_max: RST_PWM_MAX, thr_start: RST_THR_START,
        thr_idle: RST_THR_IDLE, relay_level: RST_RELAY_LEVEL
    };
    logic valve_a_held = 1'b0;
    logic valve_b_held = 1'b0;

    logic [CFG_DATA_W-1:0] reg_val[8];

    int n_err = 0;
    int n_results = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_cnt = 0;
    bit hold_done = 1'b0;
    int pat_mode = 0;
    int pat_left = 0;

    lever_to_pwm_throttle_valve_map_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Works out the actuator command for one lever beat and advances the valve state.
    function automatic t_actuator_cmd map_lever(t_lever_beat b);
        t_actuator_cmd res;
        longint a, st, kn, en, mn, mx, ts, idle, rl, q;
        a    = (longint'(b.lever) >= FS) ? FS : longint'(b.lever);
        st   = longint'(model_cfg.pwm_start);
        kn   = longint'(model_cfg.pwm_knee);
        en   = longint'(model_cfg.pwm_end);
        mn   = longint'(model_cfg.pwm_min);
        mx   = longint'(model_cfg.pwm_max);
        ts   = longint'(model_cfg.thr_start);
        idle = longint'(model_cfg.thr_idle);
        rl   = longint'(model_cfg.relay_level);

        if (a + longint'(VALVE_HYST) < VEN) begin
            valve_a_held = 1'b0;
            valve_b_held = 1'b0;
        end else if (a >= VEN) begin
            valve_a_held = b.up;
            valve_b_held = b.down;
        end

        if (a > en) begin
            q = mx;
        end else if (a >= kn) begin
            if (en - kn <= 0) begin
                q = mn;
            end else begin
                q = mn + (a - kn) * (mx - mn) / (en - kn);
            end
        end else if (a >= st) begin
            q = (kn <= st) ? 0 : (a - st) * mn / (kn - st);
        end else begin
            q = 0;
        end
        res.duty = q[DUTY_W-1:0];

        if (a <= ts || FS <= ts) begin
            q = idle;
        end else begin
            q = (a - ts) * (longint'(DAC_TOP) - idle) / (FS - ts) + idle;
        end
        res.code    = q[CODE_W-1:0];
        res.relay   = (a >= rl);
        res.valve_a = valve_a_held;
        res.valve_b = valve_b_held;
        return res;
    endfunction

    function automatic logic [LEVER_W-1:0] pick_lever();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            return LEVER_W'($urandom_range(0, 65535));
        end else if (r < 24) begin
            return LEVER_W'($urandom_range(32'(VEN - 8), 32'(VEN + 8)));
        end else if (r < 50) begin
            case ($urandom_range(0, 6))
                0: t = int'(model_cfg.pwm_start);
                1: t = int'(model_cfg.pwm_knee);
                2: t = int'(model_cfg.pwm_end);
                3: t = int'(model_cfg.thr_start);
                4: t = int'(model_cfg.relay_level);
                5: t = int'(FS);
                default: t = 0;
            endcase
            t = t + int'($urandom_range(0, 6)) - 3;
            return LEVER_W'((t < 0) ? 0 : t);
        end
        return LEVER_W'($urandom_range(0, 4095));
    endfunction

    task automatic push_beat(int lever, bit up, bit down);
        t_lever_beat b;
        b.lever = LEVER_W'(lever);
        b.up    = up;
        b.down  = down;
        lever_beats.push_back(b);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_PWM_START:   model_cfg.pwm_start   = data[LEVEL_W-1:0];
            REG_PWM_KNEE:    model_cfg.pwm_knee    = data[LEVEL_W-1:0];
            REG_PWM_END:     model_cfg.pwm_end     = data[LEVEL_W-1:0];
            REG_PWM_MIN:     model_cfg.pwm_min     = data[DUTY_W-1:0];
            REG_PWM_MAX:     model_cfg.pwm_max     = data[DUTY_W-1:0];
            REG_THR_START:   model_cfg.thr_start   = data[LEVEL_W-1:0];
            REG_THR_IDLE:    model_cfg.thr_idle    = data[CODE_W-1:0];
            REG_RELAY_LEVEL: model_cfg.relay_level = data[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config();
        for (int i = 0; i < 8; i++) begin
            write_reg(t_reg_idx'(i), reg_val[i]);
        end
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (lever_beats.size() != 0 || i_s_tvalid || actuator_cmds_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            n_err++;
        end
    endtask

    // Sender: bursts of beats separated by random gaps, some bursts run back to back.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                actuator_cmds_due.push_back(map_lever(beat_on_bus));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (lever_beats.size() > 0) begin
                    beat_on_bus = lever_beats.pop_front();
                    i_s_tdata   <= {6'b0, beat_on_bus.down, beat_on_bus.up, beat_on_bus.lever};
                    i_s_tvalid  <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat and stalls in changing patterns, once for a long stretch.
    always @(posedge i_clk) begin
        t_actuator_cmd want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (actuator_cmds_due.size() == 0) begin
                    $display("%0t unexpected result beat %h", $time, o_m_tdata);
                    n_err++;
                end else begin
                    want = actuator_cmds_due.pop_front();
                    check_field("pwm_duty", longint'(want.duty), longint'(o_m_tdata[15:0]));
                    check_field("throttle_code", longint'(want.code),
                                longint'(o_m_tdata[27:16]));
                    check_field("relay_on", longint'(want.relay), longint'(o_m_tdata[28]));
                    check_field("valve_a_drive", longint'(want.valve_a),
                                longint'(o_m_tdata[29]));
                    check_field("valve_b_drive", longint'(want.valve_b),
                                longint'(o_m_tdata[30]));
                end
                n_results++;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (!hold_done && n_results == 120) begin
                hold_done = 1'b1;
                hold_cnt  = 300;
                i_m_tready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 2);
                    pat_left = $urandom_range(20, 100);
                end
                pat_left--;
                case (pat_mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(0, 1, 1);
        push_beat(99, 0, 1);
        push_beat(100, 1, 0);
        push_beat(101, 0, 0);
        push_beat(250, 1, 1);
        push_beat(399, 0, 1);
        push_beat(400, 1, 0);
        push_beat(401, 1, 1);
        push_beat(1999, 0, 0);
        push_beat(2000, 1, 0);
        push_beat(2001, 0, 1);
        push_beat(3900, 1, 1);
        push_beat(3901, 0, 0);
        push_beat(4094, 1, 0);
        push_beat(4095, 0, 1);
        push_beat(4096, 1, 1);
        push_beat(65535, 1, 1);
        // Valves on, then through the hold band (they keep their state) and off below it.
        push_beat(200, 1, 1);
        push_beat(197, 0, 0);
        push_beat(196, 0, 1);
        push_beat(195, 1, 1);
        push_beat(199, 1, 1);
        push_beat(200, 0, 1);
        push_beat(210, 1, 0);
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: reg_val = '{default: 16'h0000};
                1: reg_val = '{default: 16'hFFFF};
                2: reg_val = '{16'd50, 16'd1000, 16'd3000, 16'd60000, 16'd200,
                               16'd100, 16'd4095, 16'd0};
                3: reg_val = '{16'd3000, 16'd1000, 16'd500, 16'd1234, 16'd65535,
                               16'd4094, 16'd0, 16'd4095};
                default: begin
                    foreach (reg_val[i]) begin
                        reg_val[i] = CFG_DATA_W'($urandom_range(0, 65535));
                    end
                end
            endcase
            load_config();
            repeat (PER_PHASE) begin
                push_beat(int'(pick_lever()), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end
            wait_drained();
        end

        repeat (40) @(posedge i_clk);
        if (n_err == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
